// File: hw/rtl/aed_pkg.sv
// ----------------------------------------------------------------------------
// aed_pkg: shared types and constants of the envelope detector
// Sequencer states, register indexes, detect modes and fixed-point widths.
// ----------------------------------------------------------------------------
package aed_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned LevelW  = 17;
	localparam int unsigned CoefW   = 16;
	localparam int unsigned MulW    = 17;
	localparam int unsigned ProdW   = 2 * MulW;
	localparam int unsigned RadW    = 2 * LevelW;
	localparam int unsigned RemW    = LevelW + 2;
	localparam int unsigned CntW    = 5;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned OutTdW  = 24;

	localparam logic [LevelW-1:0] OneQ16     = 17'h10000;
	localparam logic [ProdW-1:0]  SqRound    = 34'd8192;
	localparam logic [ProdW-1:0]  StepRound  = 34'd32768;
	localparam logic [CntW-1:0]   RootLast   = 5'(LevelW - 1);

	typedef enum logic [1:0] {
		MODE_PEAK = 2'd0,
		MODE_MS   = 2'd1,
		MODE_RMS  = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE    = 2'd0,
		REG_ATTACK  = 2'd1,
		REG_RELEASE = 2'd2,
		REG_CLAMP   = 2'd3
	} reg_idx_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SQUARE = 6'b000010,
		ST_DIFF   = 6'b000100,
		ST_SMOOTH = 6'b001000,
		ST_ROOT   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

endpackage

// File: hw/rtl/audio_envelope_detector_core.sv
// ----------------------------------------------------------------------------
// audio_envelope_detector_core: attack/release envelope follower
// Peak, mean-square and RMS level detection on Q1.15 audio samples.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one signed Q1.15 sample per beat. s_axis_tready is high
//    only while the sequencer is idle, so one sample is in work at a time.
//  - m_axis carries one Q1.16 level per accepted sample.
//  - cfg_we/cfg_index/cfg_data write the four control registers
//    (mode, attack, release, clamp); write them only while the block is idle.
// Timing:
//  - One shared 17x17 multiplier serves the square and the smoother step;
//    a restoring square root retires one result bit per cycle.
//  - Peak and mean-square modes: after the accepted beat the sequencer
//    steps through square, difference and smooth to the load state, then
//    returns to idle and takes the next sample.
//  - RMS mode: the root iterations for the 17-bit level run between the
//    smooth and load states, so the next sample waits for them as well.
// Reset clears the control registers, the sequencer state, the envelope and the output valid.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and worked on, and it waits in the load state until
// the output register frees up.
// ----------------------------------------------------------------------------
module audio_envelope_detector_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [aed_pkg::SampleW-1:0]   s_axis_tdata,   // [15:0] sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [aed_pkg::OutTdW-1:0]    m_axis_tdata,   // [16:0] level, rest zero
	input  logic                          cfg_we,
	input  logic [aed_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [aed_pkg::CfgW-1:0]      cfg_data
);

	aed_pkg::state_t                 state_q;
	aed_pkg::mode_t                  mode_q;
	logic [aed_pkg::CoefW-1:0]       attack_q;
	logic [aed_pkg::CoefW-1:0]       release_q;
	logic                            clamp_q;
	logic [aed_pkg::LevelW-1:0]      envelope_q;

	logic [aed_pkg::SampleW-1:0]     mag_q;
	logic [aed_pkg::LevelW-1:0]      x_q;
	logic [aed_pkg::LevelW-1:0]      d_q;
	logic [aed_pkg::CoefW-1:0]       coef_q;
	logic                            env_ge_q;
	logic [aed_pkg::RadW-1:0]        rad_q;
	logic [aed_pkg::RemW-1:0]        rem_q;
	logic [aed_pkg::LevelW-1:0]      root_q;
	logic [aed_pkg::CntW-1:0]        cnt_q;
	logic [aed_pkg::LevelW-1:0]      level_q;
	logic                            out_valid_q;

	logic                            in_beat;
	logic                            squared;
	logic [aed_pkg::SampleW:0]       mag_ext;
	logic [aed_pkg::MulW-1:0]        mul_a;
	logic [aed_pkg::MulW-1:0]        mul_b;
	logic [aed_pkg::ProdW-1:0]       prod;
	logic [aed_pkg::ProdW-1:0]       sq_rnd;
	logic [aed_pkg::ProdW-1:0]       step_rnd;
	logic [aed_pkg::LevelW-1:0]      step;
	logic [aed_pkg::LevelW:0]        nv_sum;
	logic [aed_pkg::LevelW:0]        nv_clamped;
	logic [aed_pkg::LevelW-1:0]      nv;
	logic [aed_pkg::RemW+1:0]        rem_sh;
	logic [aed_pkg::RemW+1:0]        trial;
	logic                            root_take;
	logic                            out_free;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == aed_pkg::ST_IDLE);
	assign squared       = (mode_q == aed_pkg::MODE_MS) || (mode_q == aed_pkg::MODE_RMS);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(aed_pkg::OutTdW - aed_pkg::LevelW){1'b0}}, level_q};

	// Two's complement magnitude; 0x8000 becomes 32768, which still fits.
	assign mag_ext = s_axis_tdata[aed_pkg::SampleW-1]
		? (17'h10000 - {1'b0, s_axis_tdata})
		: {1'b0, s_axis_tdata};

	// Shared multiplier: square of the magnitude, then coef times distance.
	always_comb begin
		if (state_q == aed_pkg::ST_SQUARE) begin
			mul_a = {1'b0, mag_q};
			mul_b = {1'b0, mag_q};
		end else begin
			mul_a = {1'b0, coef_q};
			mul_b = d_q;
		end
	end
	assign prod = {{(aed_pkg::ProdW - aed_pkg::MulW){1'b0}}, mul_a}
		* {{(aed_pkg::ProdW - aed_pkg::MulW){1'b0}}, mul_b};

	// Q2.30 to Q1.16 for the square, Q1.32 to Q1.16 for the step; both round half up.
	assign sq_rnd   = (prod + aed_pkg::SqRound) >> 14;
	assign step_rnd = (prod + aed_pkg::StepRound) >> 16;
	assign step     = step_rnd[aed_pkg::LevelW-1:0];

	// Move from x toward the old envelope by the rounded step.
	always_comb begin
		if (env_ge_q) begin
			nv_sum = {1'b0, x_q} + {1'b0, step};
		end else if (step > x_q) begin
			nv_sum = '0;
		end else begin
			nv_sum = {1'b0, x_q - step};
		end
		if (clamp_q && (nv_sum > {1'b0, aed_pkg::OneQ16})) begin
			nv_clamped = {1'b0, aed_pkg::OneQ16};
		end else begin
			nv_clamped = nv_sum;
		end
	end
	assign nv = nv_clamped[aed_pkg::LevelW-1:0];

	// Restoring square root: bring in two radicand bits, try root*4+1.
	assign rem_sh    = {rem_q, rad_q[aed_pkg::RadW-1 -: 2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign root_take = (rem_sh >= trial);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= aed_pkg::MODE_PEAK;
			attack_q  <= '0;
			release_q <= '0;
			clamp_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				aed_pkg::REG_MODE:    mode_q    <= aed_pkg::mode_t'(cfg_data[1:0]);
				aed_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				aed_pkg::REG_RELEASE: release_q <= cfg_data;
				aed_pkg::REG_CLAMP:   clamp_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Output valid: a new load wins over the drain of the previous beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == aed_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and envelope.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aed_pkg::ST_IDLE;
			envelope_q  <= '0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				aed_pkg::ST_IDLE: begin
					if (in_beat) begin
						state_q <= aed_pkg::ST_SQUARE;
					end
				end
				aed_pkg::ST_SQUARE: begin
					state_q <= aed_pkg::ST_DIFF;
				end
				aed_pkg::ST_DIFF: begin
					state_q <= aed_pkg::ST_SMOOTH;
				end
				aed_pkg::ST_SMOOTH: begin
					envelope_q <= nv;
					cnt_q      <= '0;
					state_q    <= (mode_q == aed_pkg::MODE_RMS)
						? aed_pkg::ST_ROOT : aed_pkg::ST_DONE;
				end
				aed_pkg::ST_ROOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == aed_pkg::RootLast) begin
						state_q <= aed_pkg::ST_DONE;
					end
				end
				aed_pkg::ST_DONE: begin
					// Hold here until the output register can take the level.
					if (out_free) begin
						state_q <= aed_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= aed_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			aed_pkg::ST_IDLE: begin
				if (in_beat) begin
					mag_q <= mag_ext[aed_pkg::SampleW-1:0];
				end
			end
			aed_pkg::ST_SQUARE: begin
				x_q <= squared ? sq_rnd[aed_pkg::LevelW-1:0] : {mag_q, 1'b0};
			end
			aed_pkg::ST_DIFF: begin
				env_ge_q <= (envelope_q >= x_q);
				d_q      <= (envelope_q >= x_q) ? (envelope_q - x_q) : (x_q - envelope_q);
				coef_q   <= (x_q > envelope_q) ? attack_q : release_q;
			end
			aed_pkg::ST_SMOOTH: begin
				rad_q  <= {1'b0, nv, 16'h0000};
				rem_q  <= '0;
				root_q <= '0;
			end
			aed_pkg::ST_ROOT: begin
				rad_q <= rad_q << 2;
				if (root_take) begin
					rem_q  <= aed_pkg::RemW'(rem_sh - trial);
					root_q <= {root_q[aed_pkg::LevelW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[aed_pkg::RemW-1:0];
					root_q <= {root_q[aed_pkg::LevelW-2:0], 1'b0};
				end
			end
			aed_pkg::ST_DONE: begin
				if (out_free) begin
					level_q <= (mode_q == aed_pkg::MODE_RMS) ? root_q : envelope_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// The envelope always lies between old envelope and new input, so 1.0 bounds it.
	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		envelope_q <= aed_pkg::OneQ16)
		else $error("envelope above 1.0");

	// An accepted beat starts the sequencer at the square step.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == aed_pkg::ST_SQUARE))
		else $error("accepted beat did not start the sequencer");

	// The root loop never overruns its iteration count.
	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aed_pkg::ST_ROOT) |-> (cnt_q <= aed_pkg::RootLast))
		else $error("root iteration count overrun");

	// Leaving the load state always presents a new level.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == aed_pkg::ST_DONE) && out_free) |=> out_valid_q)
		else $error("level not presented after load");
`endif

endmodule
